// ===== rtl/core/tfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfla_pkg: shared definitions of the tiered free list allocator
// Field widths, reset values, command and status codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package tfla_pkg;

  // fixed field widths
  localparam int unsigned STRIDE_W   = 21;
  localparam int unsigned TIER_W     = 2;
  localparam int unsigned HANDLE_W   = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TIER_SHIFT = 62;

  // reset and default values
  localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 21'd64;
  localparam int unsigned         SLOT_COUNT_DEF = 256;
  localparam int unsigned         NUM_POOLS_DEF  = 3;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_COMMIT
  } state_e;

endpackage

// ===== rtl/core/tiered_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_free_list_allocator: LIFO chunk free lists, one per memory tier
// Pops slots into handles on allocate and pushes slots back on free, with a
// shared add/subtract unit doing the slot times stride product and the
// offset by stride division one bit per cycle.
// ----------------------------------------------------------------------------
// Usage:
// - command beat: start and the payload (cmd_i, tier_i, handle_in_i) are
//   taken at a rising edge with start high and busy low
// - result beat: done_o is high for exactly one cycle with status_o and
//   handle_out_o; the receiver cannot stall it and must take it then
// - configuration: cfg_we_i writes cfg_wdata_i, a zero taken as one, into the
//   chunk stride; write it only while busy is low and no result is pending
// - an allocate or a free that passes the early checks goes through DECODE,
//   the MUL or DIV loop over the SW = clog2(SLOT_COUNT) slot bits and
//   COMMIT before its result shows; a missing tier, an empty pool or an out
//   of range handle gets its result straight from DECODE
// - the slot product and the offset division go through one add/subtract
//   unit, one slot bit per cycle; that loop sets the item time
// - the next command is taken in the cycle that shows the previous result
// - reset: after rst_ni the next-slot memory is swept, one entry a cycle,
//   over all NUM_POOLS << SW entries (768 by default) with busy high; then all
//   slots are free with the highest slot at the head of every tier
// ----------------------------------------------------------------------------
module tiered_free_list_allocator
  import tfla_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned NUM_POOLS  = NUM_POOLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [TIER_W-1:0]   tier_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  input  logic                cfg_we_i,
  input  logic [STRIDE_W-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o
);

  localparam int unsigned SW        = $clog2(SLOT_COUNT);
  localparam int unsigned CW        = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned MEM_DEPTH = NUM_POOLS << SW;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned LW        = STRIDE_W + CW;
  localparam int unsigned STW       = $clog2(SW + 1);

  // state
  state_e               state_q, state_d;
  logic [STRIDE_W-1:0]  stride_q, stride_d;
  logic [LW-1:0]        limit_q, limit_d;
  logic                 cmd_q, cmd_d;
  logic [TIER_W-1:0]    pool_q, pool_d;
  logic [HANDLE_W-1:0]  hin_q, hin_d;
  logic [LW-1:0]        rem_q, rem_d;
  logic [LW-1:0]        div_q, div_d;
  logic [SW-1:0]        quo_q, quo_d;
  logic [STW-1:0]       step_q, step_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 done_q, done_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [HANDLE_W-1:0]  hout_q, hout_d;

  logic [SW-1:0]        head_q [NUM_POOLS];
  logic [SW-1:0]        head_d [NUM_POOLS];
  logic                 empty_q [NUM_POOLS];
  logic                 empty_d [NUM_POOLS];
  logic [CW-1:0]        cnt_q [NUM_POOLS];
  logic [CW-1:0]        cnt_d [NUM_POOLS];

  // next-slot memory
  logic [SW-1:0]        next_mem [MEM_DEPTH];
  logic [SW-1:0]        rdata_q;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [SW-1:0]        mem_wdata;

  // shared add/subtract unit
  logic [LW-1:0]        unit_a, unit_b;
  logic                 unit_sub;
  logic [LW:0]          unit_res;

  logic [PW-1:0]        pidx;
  logic                 pool_ok;
  logic [LW-1:0]        off_lo;
  logic                 off_hi;
  logic [STRIDE_W-1:0]  cfg_eff;
  logic [SW-1:0]        clr_slot;

  assign pidx     = pool_q[PW-1:0];
  assign pool_ok  = {1'b0, pool_q} < 3'(NUM_POOLS);
  assign off_lo   = hin_q[LW-1:0];
  assign off_hi   = |hin_q[TIER_SHIFT-1:LW];
  assign cfg_eff  = (cfg_wdata_i == '0) ? STRIDE_W'(1) : cfg_wdata_i;
  assign clr_slot = clr_q[SW-1:0];
  assign rd_addr  = AW'({pidx, head_q[pidx]});

  assign unit_res = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                             : ({1'b0, unit_a} + {1'b0, unit_b});

  // operand select for the shared unit
  always_comb begin
    if (state_q == ST_DIV) begin
      unit_a   = rem_q;
      unit_b   = div_q;
      unit_sub = 1'b1;
    end else begin
      unit_a   = LW'({rem_q, 1'b0});
      unit_b   = quo_q[SW-1] ? LW'(stride_q) : '0;
      unit_sub = 1'b0;
    end
  end

  // sequencer: next state, datapath and table updates
  always_comb begin
    state_d   = state_q;
    stride_d  = stride_q;
    limit_d   = limit_q;
    cmd_d     = cmd_q;
    pool_d    = pool_q;
    hin_d     = hin_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quo_d     = quo_q;
    step_d    = step_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    status_d  = status_q;
    hout_d    = hout_q;
    head_d    = head_q;
    empty_d   = empty_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = (clr_slot == '0) ? '0 : clr_slot - SW'(1);

    // stride register and its range bound
    if (cfg_we_i) begin
      stride_d = cfg_eff;
      limit_d  = LW'(LW'(cfg_eff) * LW'(SLOT_COUNT));
    end

    case (state_q)
      // sweep the next-slot memory after reset
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      // take a command beat
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          pool_d  = (cmd_i == CMD_FREE) ? handle_in_i[HANDLE_W-1:TIER_SHIFT] : tier_i;
          hin_d   = handle_in_i;
          state_d = ST_DECODE;
        end
      end

      // early checks and unit setup
      ST_DECODE: begin
        step_d = STW'(SW - 1);
        if (cmd_q == CMD_ALLOC) begin
          if (!pool_ok || empty_q[pidx]) begin
            done_d   = 1'b1;
            status_d = STAT_EMPTY;
            hout_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            rem_d   = '0;
            quo_d   = head_q[pidx];
            state_d = ST_MUL;
          end
        end else begin
          if (!pool_ok || off_hi || off_lo >= limit_q) begin
            done_d   = 1'b1;
            status_d = STAT_BAD;
            hout_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            rem_d   = off_lo;
            div_d   = LW'(stride_q) << (SW - 1);
            quo_d   = '0;
            state_d = ST_DIV;
          end
        end
      end

      // slot times stride, msb first
      ST_MUL: begin
        rem_d  = unit_res[LW-1:0];
        quo_d  = SW'({quo_q, 1'b0});
        step_d = step_q - STW'(1);
        if (step_q == '0) begin
          state_d = ST_COMMIT;
        end
      end

      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        if (!unit_res[LW]) begin
          rem_d = unit_res[LW-1:0];
        end
        quo_d  = SW'({quo_q, !unit_res[LW]});
        div_d  = div_q >> 1;
        step_d = step_q - STW'(1);
        if (step_q == '0) begin
          state_d = ST_COMMIT;
        end
      end

      // update the list and present the result
      ST_COMMIT: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_ALLOC) begin
          status_d    = STAT_OK;
          hout_d      = {pool_q, TIER_SHIFT'(rem_q)};
          cnt_d[pidx] = cnt_q[pidx] - CW'(1);
          if (cnt_q[pidx] == CW'(1)) begin
            empty_d[pidx] = 1'b1;
          end else begin
            head_d[pidx] = rdata_q;
          end
        end else if (rem_q != '0) begin
          status_d = STAT_BAD;
          hout_d   = '0;
        end else begin
          status_d      = STAT_OK;
          hout_d        = '0;
          mem_we        = 1'b1;
          mem_waddr     = AW'({pidx, quo_q});
          mem_wdata     = empty_q[pidx] ? '0 : head_q[pidx];
          head_d[pidx]  = quo_q;
          empty_d[pidx] = 1'b0;
          if (cnt_q[pidx] < CW'(SLOT_COUNT)) begin
            cnt_d[pidx] = cnt_q[pidx] + CW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      stride_q <= STRIDE_RESET;
      limit_q  <= LW'(LW'(STRIDE_RESET) * LW'(SLOT_COUNT));
      clr_q    <= '0;
      step_q   <= '0;
      cmd_q    <= CMD_ALLOC;
      done_q   <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        head_q[p]  <= SW'(SLOT_COUNT - 1);
        empty_q[p] <= 1'b0;
        cnt_q[p]   <= CW'(SLOT_COUNT);
      end
    end else begin
      state_q  <= state_d;
      stride_q <= stride_d;
      limit_q  <= limit_d;
      clr_q    <= clr_d;
      step_q   <= step_d;
      cmd_q    <= cmd_d;
      done_q   <= done_d;
      head_q   <= head_d;
      empty_q  <= empty_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pool_q   <= pool_d;
    hin_q    <= hin_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    quo_q    <= quo_d;
    status_q <= status_d;
    hout_q   <= hout_d;
  end

  // next-slot memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      next_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= next_mem[rd_addr];
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign handle_out_o = hout_q;

endmodule

// ===== rtl/core/tfla_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfla_checker: port-level checks of the tiered free list allocator
// Watches the command and result beats and the result payload.
// ----------------------------------------------------------------------------
module tfla_checker
  import tfla_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [HANDLE_W-1:0] handle_out_o
);

  // a taken command beat keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command beat did not raise busy");

  // a result beat lasts a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat held for more than one cycle");

  // status code is always a defined one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_OK || status_o == STAT_EMPTY ||
                status_o == STAT_BAD))
    else $error("undefined status code");

  // a failed command returns a zero handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STAT_OK |-> handle_out_o == '0)
    else $error("nonzero handle on failed command");

  // a result beat only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy))
    else $error("result beat without a command in flight");

endmodule

bind tiered_free_list_allocator tfla_checker u_tfla_checker (.*);
